/* sv/nlq_pkg.sv */
package nlq_pkg;

	// Default depth of the neighbor table.
	localparam int NLQ_TABLE_ENTRIES = 64;

	// Header checks: the version nibble must match, the TTL nibble must be nonzero.
	localparam logic [3:0] NLQ_HDR_VERSION = 4'h1;
	localparam logic [3:0] NLQ_TTL_MASK    = 4'hF;

	// Gap average in 8.8 fixed point: avg = 64*gap + floor(192*avg/256).
	localparam logic [15:0] NLQ_GAP_UNITY       = 16'h0100;
	localparam int          NLQ_GAP_ALPHA_SHIFT = 6;
	localparam logic [7:0]  NLQ_GAP_KEEP        = 8'd192;
	localparam int          NLQ_UNITY_SHIFT     = 8;

	// Result codes.
	typedef enum logic [2:0] {
		ST_KNOWN      = 3'd0,
		ST_NEW        = 3'd1,
		ST_BAD_HEADER = 3'd2,
		ST_OWN_ADDR   = 3'd3,
		ST_FULL       = 3'd4
	} nlq_status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_UPDATE
	} nlq_state_t;

	// One table entry as stored in the memory.
	typedef struct packed {
		logic [15:0] address;
		logic [7:0]  last_sequence;
		logic [15:0] average_gap;
		logic [7:0]  signal_strength;
		logic [7:0]  link_quality;
	} nlq_entry_t;

endpackage

/* sv/nlq_if.sv */
// Channel that carries one received packet header.
interface nlq_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  header_byte;
	logic [7:0]  sequence_number;
	logic [15:0] source_address;
	logic [7:0]  signal_strength;
	logic [7:0]  link_quality;

	modport source (
		output valid, header_byte, sequence_number, source_address,
		       signal_strength, link_quality,
		input  ready
	);
	modport sink (
		input  valid, header_byte, sequence_number, source_address,
		       signal_strength, link_quality,
		output ready
	);
endinterface

// Channel that carries one lookup result.
interface nlq_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [5:0]  entry_index;
	logic [7:0]  sequence_gap;
	logic [15:0] average_gap;
	logic [15:0] ignored_count;

	modport source (
		output valid, status, entry_index, sequence_gap, average_gap, ignored_count,
		input  ready
	);
	modport sink (
		input  valid, status, entry_index, sequence_gap, average_gap, ignored_count,
		output ready
	);
endinterface

/* sv/nlq_table_mem.sv */
module nlq_table_mem #(
	parameter int TABLE_ENTRIES = nlq_pkg::NLQ_TABLE_ENTRIES,
	localparam int AW = $clog2(TABLE_ENTRIES)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  nlq_pkg::nlq_entry_t wdata,
	input  logic [AW-1:0]      raddr,
	output nlq_pkg::nlq_entry_t rdata
);
	import nlq_pkg::*;

	nlq_entry_t mem_q [TABLE_ENTRIES];
	nlq_entry_t rdata_q;

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port: data appears in the cycle after the address.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/nlq_ctrl.sv */
module nlq_ctrl #(
	parameter int TABLE_ENTRIES = nlq_pkg::NLQ_TABLE_ENTRIES,
	localparam int AW = $clog2(TABLE_ENTRIES)
) (
	input  logic                clk,
	input  logic                arst_n,
	nlq_in_if.sink              pkt,
	nlq_out_if.source           res,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data,
	output logic                mem_we,
	output logic [AW-1:0]       mem_waddr,
	output nlq_pkg::nlq_entry_t mem_wdata,
	output logic [AW-1:0]       mem_raddr,
	input  nlq_pkg::nlq_entry_t mem_rdata
);
	import nlq_pkg::*;

	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	nlq_state_t  state_q, state_d;

	// Captured input word.
	logic [7:0]  hdr_q;
	logic [7:0]  seq_q;
	logic [15:0] src_q;
	logic [7:0]  rssi_q;
	logic [7:0]  lqi_q;

	logic [15:0] own_q;
	logic [15:0] ign_q;

	// Slots fill in order and are never freed, so slot i is valid when i < fill_q.
	logic [CW-1:0] fill_q;
	logic [CW-1:0] idx_q;
	logic          pend_s1;
	logic [AW-1:0] addr_s1;

	// Entry found by the scan.
	logic [AW-1:0] slot_q;
	logic [7:0]    last_q;
	logic [15:0]   avg_q;

	// Output register.
	logic          out_valid_q;
	nlq_status_t   out_status_q;
	logic [5:0]    out_index_q;
	logic [7:0]    out_gap_q;
	logic [15:0]   out_avg_q;
	logic [15:0]   out_ign_q;

	logic          bad_hdr, own_hit, out_free, issue, hit, miss, full;
	logic [7:0]    gap_c;
	logic [23:0]   prod_c;
	logic [15:0]   new_avg_c;

	logic          emit, ign_inc, fill_inc;
	nlq_status_t   emit_status;
	logic [5:0]    emit_index;
	logic [7:0]    emit_gap;
	logic [15:0]   emit_avg;

	// Header, address and scan conditions.
	always_comb begin
		bad_hdr  = (hdr_q[7:4] != NLQ_HDR_VERSION) || ((hdr_q[3:0] & NLQ_TTL_MASK) == 4'h0);
		own_hit  = (src_q == own_q);
		out_free = !out_valid_q || res.ready;
		issue    = (state_q == S_SCAN) && (idx_q < fill_q);
		hit      = (state_q == S_SCAN) && pend_s1 && (mem_rdata.address == src_q);
		miss     = (state_q == S_SCAN) && !pend_s1 && !issue;
		full     = (fill_q == CW'(TABLE_ENTRIES));
	end

	// Gap and moving average of a known neighbor.
	always_comb begin
		gap_c     = seq_q - last_q;
		prod_c    = avg_q * NLQ_GAP_KEEP;
		new_avg_c = (16'(gap_c) << NLQ_GAP_ALPHA_SHIFT) + prod_c[NLQ_UNITY_SHIFT +: 16];
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (pkt.valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (bad_hdr || own_hit) begin
					if (out_free) begin
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_UPDATE;
				end else if (miss && out_free) begin
					state_d = S_IDLE;
				end
			end
			S_UPDATE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Result, memory write and counter updates.
	always_comb begin
		emit        = 1'b0;
		ign_inc     = 1'b0;
		fill_inc    = 1'b0;
		emit_status = ST_KNOWN;
		emit_index  = '0;
		emit_gap    = '0;
		emit_avg    = '0;
		mem_we      = 1'b0;
		mem_waddr   = slot_q;
		mem_wdata   = '{address: src_q, last_sequence: seq_q, average_gap: new_avg_c,
		                signal_strength: rssi_q, link_quality: lqi_q};
		unique case (state_q)
			S_CHECK: begin
				if ((bad_hdr || own_hit) && out_free) begin
					emit        = 1'b1;
					ign_inc     = 1'b1;
					emit_status = bad_hdr ? ST_BAD_HEADER : ST_OWN_ADDR;
				end
			end
			S_SCAN: begin
				if (miss && out_free) begin
					emit = 1'b1;
					if (full) begin
						emit_status = ST_FULL;
					end else begin
						// A new neighbor starts with gap one and average unity.
						emit_status           = ST_NEW;
						emit_index            = 6'(fill_q);
						emit_gap              = 8'd1;
						emit_avg              = NLQ_GAP_UNITY;
						fill_inc              = 1'b1;
						mem_we                = 1'b1;
						mem_waddr             = AW'(fill_q);
						mem_wdata.average_gap = NLQ_GAP_UNITY;
					end
				end
			end
			S_UPDATE: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_status = ST_KNOWN;
					emit_index  = 6'(slot_q);
					emit_gap    = gap_c;
					emit_avg    = new_avg_c;
					mem_we      = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign mem_raddr = idx_q[AW-1:0];

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			own_q       <= '0;
			ign_q       <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				own_q <= cfg_data;
			end
			if (ign_inc) begin
				ign_q <= ign_q + 16'd1;
			end
			if (fill_inc) begin
				fill_q <= fill_q + CW'(1);
			end
			if (state_q == S_CHECK) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			pend_s1 <= issue;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			hdr_q  <= pkt.header_byte;
			seq_q  <= pkt.sequence_number;
			src_q  <= pkt.source_address;
			rssi_q <= pkt.signal_strength;
			lqi_q  <= pkt.link_quality;
		end
		addr_s1 <= idx_q[AW-1:0];
		if (hit) begin
			slot_q <= addr_s1;
			last_q <= mem_rdata.last_sequence;
			avg_q  <= mem_rdata.average_gap;
		end
		if (emit) begin
			out_status_q <= emit_status;
			out_index_q  <= emit_index;
			out_gap_q    <= emit_gap;
			out_avg_q    <= emit_avg;
			out_ign_q    <= ign_inc ? (ign_q + 16'd1) : ign_q;
		end
	end

	assign pkt.ready         = (state_q == S_IDLE);
	assign res.valid         = out_valid_q;
	assign res.status        = out_status_q;
	assign res.entry_index   = out_index_q;
	assign res.sequence_gap  = out_gap_q;
	assign res.average_gap   = out_avg_q;
	assign res.ignored_count = out_ign_q;

endmodule

/* sv/neighbor_link_quality_table_top.sv */
// Neighbor link-quality table.
// The pkt channel takes one received broadcast header per word: header byte,
// sequence number, source address, RSSI and LQI. The res channel returns one
// result word per packet: status, table slot, sequence gap, the updated 8.8
// gap average and the running count of ignored packets.
// cfg_we writes cfg_data into the node's own address; packets from it are ignored.
// A packet with a bad header or the own address gets its result from the check
// state without a scan. Any other packet scans the filled part of the table
// one entry per cycle through the registered memory read port, stopping at a
// match. One packet is worked on at a time; pkt.ready is high again from the
// clock edge that loads the result into the output register.
// A result waiting in the output register while res.ready is low does not
// block acceptance of the next packet; the block only stalls when a second
// result is ready and the first is still not taken.
// Reset empties the table at once (slots are handed out in order, so a fill
// count marks the valid ones), clears the ignored counter and the own address.
module neighbor_link_quality_table_top #(
	parameter int TABLE_ENTRIES = nlq_pkg::NLQ_TABLE_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	nlq_in_if.sink      pkt,
	nlq_out_if.source   res,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data
);
	import nlq_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;
	nlq_entry_t    mem_wdata;
	nlq_entry_t    mem_rdata;

	// Lookup and update sequencer.
	nlq_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt       (pkt),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Neighbor entry storage.
	nlq_table_mem #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

`ifndef SYNTH
	// The table is never written in a cycle that accepts a new packet.
	a_no_write_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !(pkt.valid && pkt.ready))
		else $error("table write while accepting a packet");

	// Ignored and dropped packets carry zero slot, gap and average.
	a_drop_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.status == ST_BAD_HEADER || res.status == ST_OWN_ADDR ||
		               res.status == ST_FULL))
		|-> (res.entry_index == 6'd0 && res.sequence_gap == 8'd0 &&
		     res.average_gap == 16'd0))
		else $error("dropped packet with nonzero result fields");

	// A new neighbor always reports gap one and average unity.
	a_new_entry_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.status == ST_NEW)
		|-> (res.sequence_gap == 8'd1 && res.average_gap == NLQ_GAP_UNITY))
		else $error("new neighbor with wrong gap or average");
`endif

endmodule

/* test/neighbor_link_quality_table_top_tb.sv */
module neighbor_link_quality_table_top_tb;
	import nlq_pkg::*;

	// Gap average weights: new average = 64*gap + floor(192*old/256).
	localparam int unsigned GAP_WEIGHT  = 64;
	localparam int unsigned AVG_KEEP    = 192;
	localparam int          KEEP_SHIFT  = 8;
	localparam int          POOL_SIZE   = 72;
	localparam int          SETTLE_CYCLES = 8;
	localparam int          TAIL_CYCLES = NLQ_TABLE_ENTRIES + 8;
	localparam int          IGNORED_BURST = 120;

	typedef struct {
		nlq_status_t status;
		logic [5:0]  entry_index;
		logic [7:0]  sequence_gap;
		logic [15:0] average_gap;
		logic [15:0] ignored_count;
	} link_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_data;

	nlq_in_if  pkt_if ();
	nlq_out_if res_if ();

	neighbor_link_quality_table_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.pkt      (pkt_if),
		.res      (res_if),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// Shadow copy of the neighbor table and the node settings.
	bit          nbr_used [NLQ_TABLE_ENTRIES];
	logic [15:0] nbr_address [NLQ_TABLE_ENTRIES];
	logic [7:0]  nbr_last_seq [NLQ_TABLE_ENTRIES];
	logic [15:0] nbr_avg_gap [NLQ_TABLE_ENTRIES];
	logic [15:0] ignored_total = '0;
	logic [15:0] node_address = '0;

	link_result_t expected_results [$];
	logic [15:0]  neighbor_pool [$];
	int           mismatch_count = 0;
	bit           quiet = 1'b0;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic int find_neighbor(input logic [15:0] addr);
		foreach (nbr_used[i])
			if (nbr_used[i] && nbr_address[i] == addr)
				return i;
		return -1;
	endfunction

	// Works out the result word for one accepted packet and updates the shadow table.
	function automatic link_result_t predict_link_update(input logic [7:0] hdr,
			input logic [7:0] seq, input logic [15:0] src);
		link_result_t r;
		int           slot;
		logic [7:0]   gap;
		int unsigned  avg;
		r.status        = ST_KNOWN;
		r.entry_index   = '0;
		r.sequence_gap  = '0;
		r.average_gap   = '0;
		if (hdr[7:4] != NLQ_HDR_VERSION || hdr[3:0] == 4'h0) begin
			ignored_total = ignored_total + 16'd1;
			r.status = ST_BAD_HEADER;
		end else if (src == node_address) begin
			ignored_total = ignored_total + 16'd1;
			r.status = ST_OWN_ADDR;
		end else begin
			slot = find_neighbor(src);
			if (slot < 0) begin
				// Unknown sender: take the lowest free slot if there is one.
				for (int i = 0; i < NLQ_TABLE_ENTRIES; i++)
					if (slot < 0 && !nbr_used[i])
						slot = i;
				if (slot < 0) begin
					r.status = ST_FULL;
				end else begin
					nbr_used[slot]     = 1'b1;
					nbr_address[slot]  = src;
					nbr_last_seq[slot] = seq - 8'd1;
					nbr_avg_gap[slot]  = NLQ_GAP_UNITY;
					r.status = ST_NEW;
				end
			end
			if (slot >= 0) begin
				gap = seq - nbr_last_seq[slot];
				avg = gap * GAP_WEIGHT + ((nbr_avg_gap[slot] * AVG_KEEP) >> KEEP_SHIFT);
				nbr_avg_gap[slot]  = avg[15:0];
				nbr_last_seq[slot] = seq;
				r.entry_index  = slot[5:0];
				r.sequence_gap = gap;
				r.average_gap  = avg[15:0];
			end
		end
		r.ignored_count = ignored_total;
		return r;
	endfunction

	// Sends one packet word after a random idle stretch; valid stays high for a back-to-back word.
	task automatic send_packet(input logic [7:0] hdr, input logic [7:0] seq,
			input logic [15:0] src, input logic [7:0] rssi, input logic [7:0] lqi);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			pkt_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt_if.valid           <= 1'b1;
		pkt_if.header_byte     <= hdr;
		pkt_if.sequence_number <= seq;
		pkt_if.source_address  <= src;
		pkt_if.signal_strength <= rssi;
		pkt_if.link_quality    <= lqi;
		do
			@(posedge clk);
		while (!pkt_if.ready);
		expected_results.push_back(predict_link_update(hdr, seq, src));
	endtask

	// Stops sending and waits until every expected word has come back.
	task automatic wait_until_idle(input int extra);
		pkt_if.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_node_address(input logic [15:0] addr);
		cfg_we   <= 1'b1;
		cfg_data <= addr;
		@(posedge clk);
		cfg_we <= 1'b0;
		node_address = addr;
	endtask

	// Bad version, zero TTL and the node's own address (zero after reset).
	task automatic test_header_checks();
		send_packet(8'h00, 8'h00, 16'h0001, 8'h00, 8'h00);
		send_packet(8'h10, 8'h01, 16'h0001, 8'h01, 8'h01);
		send_packet(8'h2F, 8'h02, 16'h0001, 8'h02, 8'h02);
		send_packet(8'hF1, 8'h03, 16'h0001, 8'h03, 8'h03);
		send_packet(8'h11, 8'h04, 16'h0000, 8'hFF, 8'hFF);
	endtask

	// New and known neighbors, gaps of zero, one, 128 and 255, and wrap of the sequence.
	task automatic test_neighbor_tracking();
		logic [7:0] seq;
		send_packet(8'h11, 8'h00, 16'hFFFF, 8'h00, 8'h00);
		send_packet(8'h1F, 8'h01, 16'hFFFF, 8'hFF, 8'hFF);
		send_packet(8'h18, 8'h01, 16'hFFFF, 8'h55, 8'hAA);
		send_packet(8'h11, 8'h00, 16'hFFFF, 8'hAA, 8'h55);
		send_packet(8'h12, 8'hFF, 16'h1234, 8'h10, 8'h20);
		send_packet(8'h13, 8'h00, 16'h1234, 8'h30, 8'h40);
		send_packet(8'h1F, 8'h80, 16'hFFFF, 8'h50, 8'h60);
		// Gaps of 255 in a row push the average toward its upper bound.
		seq = 8'h80;
		repeat (5) begin
			seq = seq - 8'd1;
			send_packet(8'h17, seq, 16'hFFFF, $urandom, $urandom);
		end
	endtask

	// A known neighbor becomes the own address; the old own address becomes a neighbor.
	task automatic test_own_address_change();
		wait_until_idle(SETTLE_CYCLES);
		write_node_address(16'hFFFF);
		send_packet(8'h15, 8'h7F, 16'hFFFF, 8'h11, 8'h22);
		send_packet(8'h1A, 8'h33, 16'h0000, 8'h44, 8'h55);
	endtask

	// A long back-to-back run of ignored packets with the result side always ready.
	task automatic test_ignored_burst();
		logic [7:0] hdr;
		wait_until_idle(SETTLE_CYCLES);
		quiet = 1'b1;
		repeat (IGNORED_BURST) begin
			hdr = $urandom;
			if (hdr[7:4] == NLQ_HDR_VERSION)
				hdr[3:0] = 4'h0;
			send_packet(hdr, $urandom, $urandom, $urandom, $urandom);
		end
		wait_until_idle(SETTLE_CYCLES);
		quiet = 1'b0;
	endtask

	// Mostly well-formed traffic from a neighbor pool larger than the table, some noise.
	task automatic test_random_traffic(input logic [15:0] own, input int count,
			input bit no_idle);
		int          kind;
		int          slot;
		logic [7:0]  hdr;
		logic [7:0]  seq;
		logic [15:0] src;
		wait_until_idle(SETTLE_CYCLES);
		write_node_address(own);
		quiet = no_idle;
		repeat (count) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				hdr = $urandom;
				src = $urandom;
				seq = $urandom;
			end else begin
				hdr = {NLQ_HDR_VERSION, 4'($urandom_range(1, 15))};
				if (kind < 12)
					src = node_address;
				else
					src = neighbor_pool[$urandom_range(0, neighbor_pool.size() - 1)];
				slot = find_neighbor(src);
				if (slot >= 0 && $urandom_range(0, 9) < 8)
					seq = nbr_last_seq[slot] + 8'($urandom_range(1, 4));
				else
					seq = $urandom;
			end
			send_packet(hdr, seq, src, $urandom, $urandom);
		end
		quiet = 1'b0;
	endtask

	task automatic build_neighbor_pool();
		logic [15:0] addr;
		bit          seen;
		neighbor_pool = '{16'hFFFF, 16'h1234, 16'h0000};
		while (neighbor_pool.size() < POOL_SIZE) begin
			addr = $urandom;
			seen = 1'b0;
			foreach (neighbor_pool[i])
				if (neighbor_pool[i] == addr)
					seen = 1'b1;
			if (!seen)
				neighbor_pool.push_back(addr);
		end
	endtask

	// Result ready: random stalls, held high while the quiet stretch runs.
	initial begin : drive_result_ready
		int hold;
		bit level;
		hold  = 0;
		level = 1'b0;
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (quiet) begin
				level = 1'b1;
				hold  = 0;
			end else begin
				if (hold == 0) begin
					if ($urandom_range(0, 2) != 0) begin
						level = 1'b1;
						hold  = $urandom_range(1, 20);
					end else begin
						level = 1'b0;
						hold  = pick_gap() + 1;
					end
				end
				hold = hold - 1;
			end
			res_if.ready <= level;
		end
	end

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			mismatch_count++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	// Each taken result word is compared with the oldest expectation.
	always @(posedge clk) begin : check_results
		link_result_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				$display("%0t: no result expected, got status %0d", $time, res_if.status);
			end else begin
				want = expected_results.pop_front();
				check_field("status", 16'(want.status), 16'(res_if.status));
				check_field("entry_index", 16'(want.entry_index), 16'(res_if.entry_index));
				check_field("sequence_gap", 16'(want.sequence_gap), 16'(res_if.sequence_gap));
				check_field("average_gap", want.average_gap, res_if.average_gap);
				check_field("ignored_count", want.ignored_count, res_if.ignored_count);
			end
		end
	end

	initial begin
		#40_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n                 <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_data               <= '0;
		pkt_if.valid           <= 1'b0;
		pkt_if.header_byte     <= '0;
		pkt_if.sequence_number <= '0;
		pkt_if.source_address  <= '0;
		pkt_if.signal_strength <= '0;
		pkt_if.link_quality    <= '0;
		build_neighbor_pool();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_header_checks();
		test_neighbor_tracking();
		test_own_address_change();
		test_ignored_burst();
		test_random_traffic(neighbor_pool[$urandom_range(3, POOL_SIZE - 1)], 500, 1'b0);
		test_random_traffic(16'h0000, 400, 1'b1);
		test_random_traffic($urandom, 450, 1'b0);
		test_random_traffic(16'hFFFF, 460, 1'b0);

		wait_until_idle(TAIL_CYCLES);
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
